>>> design/pcrm_pkg.sv
// ----------------------------------------------------------------------------
// pcrm_pkg
// Shared types, constants and field positions for the pulse counter and
// rate meter.
// ----------------------------------------------------------------------------
package pcrm_pkg;

  // Pulse count width; the count wraps at this width.
  localparam int COUNT_W        = 32;
  // Fraction bits of the result and of the pulses-per-unit register.
  localparam int VALUE_FRAC     = 16;
  localparam int PPU_FRAC       = 16;
  localparam int SCALE_SHIFT    = PPU_FRAC + VALUE_FRAC;
  // Quotient width: unsigned Q32.VALUE_FRAC.
  localparam int QUOT_W         = 32 + VALUE_FRAC;
  // Milliseconds per second, the rate scale factor.
  localparam int MS_PER_S       = 1000;
  localparam int MS_PER_S_W     = 10;
  // In rate mode the numerator is a count times 1000, denominator elapsed times ppu.
  localparam int NUM_W          = COUNT_W + MS_PER_S_W;
  localparam int DEN_W          = 64;
  // The quotient overflows when num >= den << (QUOT_W - SCALE_SHIFT).
  localparam int OVF_SHIFT      = QUOT_W - SCALE_SHIFT;
  localparam int STEP_W         = $clog2(QUOT_W);

  localparam logic [QUOT_W-1:0] VALUE_MAX = {QUOT_W{1'b1}};

  // Stream widths and field positions.
  localparam int IN_TDATA_W     = 8;
  localparam int IN_PIN_POS     = 0;
  localparam int IN_TICK_POS    = 1;
  localparam int IN_REQ_POS     = 2;

  localparam int OUT_TDATA_W    = 120;
  localparam int OUT_VALID_POS  = QUOT_W;
  localparam int OUT_SAT_POS    = QUOT_W + 1 + 32 + 32;
  localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_SAT_POS - 1;

  // Configuration port.
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_MODE  = 2'd0,
    CFG_EDGE_SELECT = 2'd1,
    CFG_WINDOW_MS   = 2'd2,
    CFG_PPU         = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  localparam logic MODE_TOTAL = 1'b0;
  localparam logic MODE_RATE  = 1'b1;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [31:0] PPU_RESET    = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_LOAD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul;
    logic check;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic ovf;
  } stat_t;

  // Result fields handed to the output register.
  typedef struct packed {
    logic              sat;
    logic [31:0]       raw;
    logic [31:0]       ts;
    logic [QUOT_W-1:0] value;
  } res_t;

endpackage

>>> design/pulse_counter_rate_meter.sv
// ----------------------------------------------------------------------------
// pulse_counter_rate_meter
// Counts edges of a sampled pin, keeps a millisecond clock and, on request,
// reports the scaled total count or the windowed rate per second.
// ----------------------------------------------------------------------------
// Sequence: an item without a request is taken while idle. A request's result
// goes to the load state without a divide (window not elapsed, zero elapsed
// time), after multiply and check on overflow, else after multiply, check and
// 48 one-bit-per-cycle divide steps. Throughput: one item per cycle while idle;
// a request holds the input until its result is loaded, plus any output wait.
// Reset (synchronous, active high) clears the FSM and loads register reset values.
module pulse_counter_rate_meter (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: [0] pin_level, [1] ms_tick, [2] sample_request, rest zero.
  input  logic [pcrm_pkg::IN_TDATA_W-1:0]      s_tdata,
  // Result stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: [47:0] value_q16, [48] value_valid, [80:49] timestamp_ms,
  // [112:81] raw_count, [113] saturated, [119:114] zero.
  output logic [pcrm_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [pcrm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcrm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pcrm_pkg::cmd_t  cmd;
  pcrm_pkg::stat_t stat;
  pcrm_pkg::res_t  res;
  logic            out_free;
  logic            out_load;

  // The output register is free when empty or when its result is being
  // transferred this cycle, so a waiting result never blocks plain samples.
  assign out_free = !m_tvalid || m_tready;

  pcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .item_req (s_tdata[pcrm_pkg::IN_REQ_POS]),
    .stat     (stat),
    .out_free (out_free),
    .s_tready (s_tready),
    .cmd      (cmd),
    .out_load (out_load)
  );

  pcrm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pin_level      (s_tdata[pcrm_pkg::IN_PIN_POS]),
    .ms_tick        (s_tdata[pcrm_pkg::IN_TICK_POS]),
    .sample_request (s_tdata[pcrm_pkg::IN_REQ_POS]),
    .cmd            (cmd),
    .stat           (stat),
    .res            (res)
  );

  // Output register. The valid flag is reset; the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{pcrm_pkg::OUT_PAD_W{1'b0}}, res.sat, res.raw, res.ts, 1'b1, res.value};
    end
  end

  // A result is loaded only into a free output register.
  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result loaded over a pending transfer");

  // A request item stops further input until its result is loaded.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[pcrm_pkg::IN_REQ_POS]) |=> !s_tready)
    else $error("input accepted while a request is in progress");

  // A saturated result carries the maximum value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[pcrm_pkg::OUT_SAT_POS]) |->
      (m_tdata[pcrm_pkg::QUOT_W-1:0] == pcrm_pkg::VALUE_MAX))
    else $error("saturated flag without maximum value");

  // Every result is marked as a valid measurement.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[pcrm_pkg::OUT_VALID_POS])
    else $error("result without value_valid");

endmodule

>>> design/pcrm_ctrl.sv
// ----------------------------------------------------------------------------
// pcrm_ctrl
// Sequencer: accepts items, runs the multiply, overflow check and the
// bit-serial divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pcrm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            item_req,
  input  pcrm_pkg::stat_t stat,
  input  logic            out_free,
  output logic            s_tready,
  output pcrm_pkg::cmd_t  cmd,
  output logic            out_load
);

  pcrm_pkg::state_t              state;
  pcrm_pkg::state_t              state_next;
  logic [pcrm_pkg::STEP_W-1:0]   step_cnt;
  logic                          last_step;

  assign last_step = (step_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pcrm_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == pcrm_pkg::ST_CHK) begin
        step_cnt <= pcrm_pkg::STEP_W'(pcrm_pkg::QUOT_W - 1);
      end else if (state == pcrm_pkg::ST_DIV) begin
        step_cnt <= step_cnt - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcrm_pkg::ST_IDLE: begin
        if (s_tvalid && item_req) begin
          state_next = stat.need_div ? pcrm_pkg::ST_MUL : pcrm_pkg::ST_LOAD;
        end
      end
      pcrm_pkg::ST_MUL:  state_next = pcrm_pkg::ST_CHK;
      pcrm_pkg::ST_CHK:  state_next = stat.ovf ? pcrm_pkg::ST_LOAD : pcrm_pkg::ST_DIV;
      pcrm_pkg::ST_DIV: begin
        if (last_step) begin
          state_next = pcrm_pkg::ST_LOAD;
        end
      end
      pcrm_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = pcrm_pkg::ST_IDLE;
        end
      end
      default: state_next = pcrm_pkg::ST_IDLE;
    endcase
  end

  // No transfer is taken while reset is held.
  always_comb begin
    s_tready   = (state == pcrm_pkg::ST_IDLE) && !rst;
    cmd.accept = (state == pcrm_pkg::ST_IDLE) && !rst && s_tvalid;
    cmd.mul    = (state == pcrm_pkg::ST_MUL);
    cmd.check  = (state == pcrm_pkg::ST_CHK);
    cmd.step   = (state == pcrm_pkg::ST_DIV);
    cmd.finish = (state == pcrm_pkg::ST_DIV) && last_step;
    out_load   = (state == pcrm_pkg::ST_LOAD) && out_free;
  end

endmodule

>>> design/pcrm_datapath.sv
// ----------------------------------------------------------------------------
// pcrm_datapath
// Configuration registers, edge counter, millisecond clock, window state,
// operand multiply and the restoring divider that forms the scaled value.
// ----------------------------------------------------------------------------
module pcrm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pcrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcrm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                pin_level,
  input  logic                                ms_tick,
  input  logic                                sample_request,
  input  pcrm_pkg::cmd_t                      cmd,
  output pcrm_pkg::stat_t                     stat,
  output pcrm_pkg::res_t                      res
);

  // Configuration.
  logic        count_mode;
  logic [1:0]  edge_select;
  logic [15:0] window_ms;
  logic [31:0] ppu;

  // Measurement state.
  logic                          previous_pin;
  logic [pcrm_pkg::COUNT_W-1:0]  pulse_total;
  logic [31:0]                   clock_ms;
  logic [31:0]                   window_start_ms;
  logic [pcrm_pkg::COUNT_W-1:0]  window_start_count;
  logic [pcrm_pkg::QUOT_W-1:0]   held_value;
  logic                          held_saturated;
  logic [31:0]                   cap_ts;
  logic [31:0]                   cap_raw;

  // Divide operands and working registers.
  logic                          op_mode;
  logic [pcrm_pkg::COUNT_W-1:0]  op_n;
  logic [31:0]                   op_e;
  logic [pcrm_pkg::NUM_W-1:0]    num;
  logic [pcrm_pkg::DEN_W-1:0]    den;
  logic [pcrm_pkg::DEN_W-1:0]    rem;
  logic [pcrm_pkg::QUOT_W-1:0]   dq;

  logic                          edge_hit;
  logic [pcrm_pkg::COUNT_W-1:0]  total_next;
  logic [31:0]                   clock_next;
  logic [31:0]                   elapsed;
  logic [pcrm_pkg::COUNT_W-1:0]  delta;
  logic                          win_done;
  logic                          take_req;
  logic [pcrm_pkg::NUM_W-pcrm_pkg::OVF_SHIFT-1:0] num_hi;
  logic [pcrm_pkg::DEN_W:0]      trial;
  logic                          trial_ge;

  always_comb begin
    case (edge_select)
      pcrm_pkg::EDGE_RISE: edge_hit = !previous_pin && pin_level;
      pcrm_pkg::EDGE_FALL: edge_hit = previous_pin && !pin_level;
      pcrm_pkg::EDGE_BOTH: edge_hit = previous_pin != pin_level;
      default:             edge_hit = 1'b0;
    endcase
  end

  assign total_next = edge_hit ? pulse_total + 1'b1 : pulse_total;
  assign clock_next = ms_tick ? clock_ms + 1'b1 : clock_ms;
  assign elapsed    = clock_next - window_start_ms;
  assign delta      = total_next - window_start_count;
  assign win_done   = elapsed >= {16'd0, window_ms};
  assign take_req   = cmd.accept && sample_request;

  // A rate request outside its window repeats the held value, and a zero
  // elapsed time gives zero; neither needs the divider.
  assign stat.need_div = (count_mode == pcrm_pkg::MODE_TOTAL) ||
                         (win_done && (elapsed != 32'd0));

  assign num_hi   = num[pcrm_pkg::NUM_W-1:pcrm_pkg::OVF_SHIFT];
  assign stat.ovf = pcrm_pkg::DEN_W'(num_hi) >= den;

  assign trial    = {rem, dq[pcrm_pkg::QUOT_W-1]};
  assign trial_ge = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode  <= pcrm_pkg::MODE_TOTAL;
      edge_select <= pcrm_pkg::EDGE_RISE;
      window_ms   <= pcrm_pkg::WINDOW_RESET;
      ppu         <= pcrm_pkg::PPU_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcrm_pkg::CFG_COUNT_MODE:  count_mode  <= cfg_data[0];
        pcrm_pkg::CFG_EDGE_SELECT: edge_select <= cfg_data[1:0];
        pcrm_pkg::CFG_WINDOW_MS:   window_ms   <= cfg_data[15:0];
        pcrm_pkg::CFG_PPU: begin
          if (cfg_data != '0) begin
            ppu <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pin       <= 1'b0;
      pulse_total        <= '0;
      clock_ms           <= '0;
      window_start_ms    <= '0;
      window_start_count <= '0;
      held_value         <= '0;
      held_saturated     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        previous_pin <= pin_level;
        pulse_total  <= total_next;
        clock_ms     <= clock_next;
      end
      if (take_req && (count_mode == pcrm_pkg::MODE_RATE) && win_done) begin
        window_start_ms    <= clock_next;
        window_start_count <= total_next;
        if (elapsed == 32'd0) begin
          held_value     <= '0;
          held_saturated <= 1'b0;
        end
      end
      if (cmd.check && stat.ovf) begin
        held_value     <= pcrm_pkg::VALUE_MAX;
        held_saturated <= 1'b1;
      end
      if (cmd.finish) begin
        held_value     <= {dq[pcrm_pkg::QUOT_W-2:0], trial_ge};
        held_saturated <= 1'b0;
      end
    end
  end

  // Operand capture, multiply and divider steps.
  always_ff @(posedge clk) begin
    if (take_req) begin
      cap_ts  <= clock_next;
      cap_raw <= total_next;
      op_mode <= count_mode;
      op_n    <= (count_mode == pcrm_pkg::MODE_RATE) ? delta : total_next;
      op_e    <= elapsed;
    end
    if (cmd.mul) begin
      if (op_mode == pcrm_pkg::MODE_RATE) begin
        num <= pcrm_pkg::NUM_W'(op_n) * pcrm_pkg::NUM_W'(pcrm_pkg::MS_PER_S);
        den <= pcrm_pkg::DEN_W'(op_e) * pcrm_pkg::DEN_W'(ppu);
      end else begin
        num <= pcrm_pkg::NUM_W'(op_n);
        den <= pcrm_pkg::DEN_W'(ppu);
      end
    end
    if (cmd.check) begin
      rem <= pcrm_pkg::DEN_W'(num_hi);
      dq  <= {num[pcrm_pkg::OVF_SHIFT-1:0], {pcrm_pkg::SCALE_SHIFT{1'b0}}};
    end
    if (cmd.step) begin
      rem <= trial_ge ? pcrm_pkg::DEN_W'(trial - {1'b0, den})
                      : pcrm_pkg::DEN_W'(trial);
      dq  <= {dq[pcrm_pkg::QUOT_W-2:0], trial_ge};
    end
  end

  assign res.value = held_value;
  assign res.sat   = held_saturated;
  assign res.ts    = cap_ts;
  assign res.raw   = cap_raw;

endmodule
